// ===== rtl/wmf_pkg.sv =====
// Shared types and constants for the weighted median finder.
// No dependencies; used by wmf_cell and weighted_median_finder_unit.
package wmf_pkg;

    // Default configuration of the unit.
    localparam int MAX_SAMPLES_DEF   = 1024;
    localparam int POSITION_BITS_DEF = 16;
    localparam int WEIGHT_BITS_DEF   = 16;

    // Fixed port field widths.
    localparam int IN_FIELD_W  = 16;
    localparam int POS_OUT_W   = 16;
    localparam int TOTAL_OUT_W = 26;
    localparam int COUNT_OUT_W = 11;

    localparam logic [TOTAL_OUT_W-1:0] TOTAL_OUT_MAX = '1;
    localparam logic [COUNT_OUT_W-1:0] COUNT_OUT_MAX = '1;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic insert;  // place the new sample in sorted order
        logic shift;   // move all entries one cell toward cell 0
    } cell_ctrl_t;

endpackage

// ===== rtl/wmf_cell.sv =====
// One cell of the sorted sample chain: holds a position and a weight.
// Depends on wmf_pkg for the command type.
module wmf_cell #(
    parameter int POS_W = 16,
    parameter int WT_W  = 16,
    parameter int CNT_W = 11,
    parameter int IDX   = 0
) (
    input  logic                clk,
    input  wmf_pkg::cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]    count,
    input  logic [POS_W-1:0]    new_pos,
    input  logic [WT_W-1:0]     new_wt,
    input  logic                left_gt,
    input  logic [POS_W-1:0]    left_pos,
    input  logic [WT_W-1:0]     left_wt,
    input  logic [POS_W-1:0]    right_pos,
    input  logic [WT_W-1:0]     right_wt,
    output logic [POS_W-1:0]    pos,
    output logic [WT_W-1:0]     wt,
    output logic                gt
);
    import wmf_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [WT_W-1:0]  wt_reg;
    logic [WT_W-1:0]  wt_next;
    logic             occupied;

    // Cells below the fill count hold live entries.
    assign occupied = CNT_W'(IDX) < count;
    assign gt       = occupied && (pos_reg > new_pos);

    always_comb
    begin
        pos_next = pos_reg;
        wt_next  = wt_reg;
        priority if (ctrl.shift)
        begin
            pos_next = right_pos;
            wt_next  = right_wt;
        end
        else if (ctrl.insert && left_gt)
        begin
            // The left neighbor moves up to make room.
            pos_next = left_pos;
            wt_next  = left_wt;
        end
        else if (ctrl.insert && (gt || !occupied))
        begin
            pos_next = new_pos;
            wt_next  = new_wt;
        end
        else
        begin
            pos_next = pos_reg;
            wt_next  = wt_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        wt_reg  <= wt_next;
    end

    assign pos = pos_reg;
    assign wt  = wt_reg;

endmodule

// ===== rtl/weighted_median_finder_unit.sv =====
// Weighted median finder: sorted insertion chain followed by a cumulative scan.
// Samples are taken one per cycle while idle and placed in order as they come.
// After the last sample the input stalls while the chain shifts out through
// cell 0, one entry per cycle, until twice the running sum reaches the total;
// the result register is then loaded once any earlier result held there by a
// stalled output has been taken.
// Reset clears all control, counts and the total; cell contents are not reset.
module weighted_median_finder_unit #(
    parameter int MAX_SAMPLES   = wmf_pkg::MAX_SAMPLES_DEF,
    parameter int POSITION_BITS = wmf_pkg::POSITION_BITS_DEF,
    parameter int WEIGHT_BITS   = wmf_pkg::WEIGHT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [wmf_pkg::IN_FIELD_W-1:0]    sample_position,
    input  logic [wmf_pkg::IN_FIELD_W-1:0]    sample_weight,
    input  logic                              last_sample,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [wmf_pkg::POS_OUT_W-1:0]     halfway_position,
    output logic [wmf_pkg::TOTAL_OUT_W-1:0]   total_weight,
    output logic [wmf_pkg::COUNT_OUT_W-1:0]   sample_count,
    output logic                              overflowed
);
    import wmf_pkg::*;

    localparam int CNT_W   = $clog2(MAX_SAMPLES + 1);
    localparam int TOT_W   = WEIGHT_BITS + CNT_W;
    localparam int TSAT_W  = (TOT_W > TOTAL_OUT_W) ? TOT_W : TOTAL_OUT_W;
    localparam int CSAT_W  = (CNT_W > COUNT_OUT_W) ? CNT_W : COUNT_OUT_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

    state_t                   state_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic [TOT_W-1:0]         total_reg;
    logic [TOT_W-1:0]         acc_reg;
    logic                     drop_reg;
    logic [POSITION_BITS-1:0] half_reg;
    logic                     out_valid_reg;
    logic [POS_OUT_W-1:0]     out_pos_reg;
    logic [TOTAL_OUT_W-1:0]   out_total_reg;
    logic [COUNT_OUT_W-1:0]   out_count_reg;
    logic                     out_ovf_reg;

    logic [POSITION_BITS-1:0] new_pos;
    logic [WEIGHT_BITS-1:0]   new_wt;
    logic                     accept;
    logic                     full;
    logic                     out_free;
    logic                     load_result;
    cell_ctrl_t               ctrl;
    logic [TOT_W-1:0]         acc_next;
    logic                     hit;
    logic                     last_one;

    logic [POSITION_BITS-1:0] pos_a [MAX_SAMPLES];
    logic [WEIGHT_BITS-1:0]   wt_a  [MAX_SAMPLES];
    logic                     gt_a  [MAX_SAMPLES];

    assign new_pos     = POSITION_BITS'(sample_position);
    assign new_wt      = WEIGHT_BITS'(sample_weight);
    assign in_stall    = (state_reg != ST_IDLE);
    assign accept      = in_valid && (state_reg == ST_IDLE);
    assign full        = (count_reg == CNT_W'(MAX_SAMPLES));
    assign out_free    = !out_valid_reg || !out_stall;
    assign load_result = (state_reg == ST_DONE) && out_free;

    assign ctrl.insert = accept && !full;
    assign ctrl.shift  = (state_reg == ST_SCAN);

    genvar g;
    generate
        for (g = 0; g < MAX_SAMPLES; g++)
        begin : g_cell
            logic                     l_gt;
            logic [POSITION_BITS-1:0] l_pos;
            logic [WEIGHT_BITS-1:0]   l_wt;
            logic [POSITION_BITS-1:0] r_pos;
            logic [WEIGHT_BITS-1:0]   r_wt;

            if (g == 0)
            begin : g_first
                assign l_gt  = 1'b0;
                assign l_pos = '0;
                assign l_wt  = '0;
            end
            else
            begin : g_mid
                assign l_gt  = gt_a[g-1];
                assign l_pos = pos_a[g-1];
                assign l_wt  = wt_a[g-1];
            end

            if (g == MAX_SAMPLES - 1)
            begin : g_last
                assign r_pos = pos_a[g];
                assign r_wt  = wt_a[g];
            end
            else
            begin : g_inner
                assign r_pos = pos_a[g+1];
                assign r_wt  = wt_a[g+1];
            end

            wmf_cell #(
                .POS_W (POSITION_BITS),
                .WT_W  (WEIGHT_BITS),
                .CNT_W (CNT_W),
                .IDX   (g)
            ) u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .count     (count_reg),
                .new_pos   (new_pos),
                .new_wt    (new_wt),
                .left_gt   (l_gt),
                .left_pos  (l_pos),
                .left_wt   (l_wt),
                .right_pos (r_pos),
                .right_wt  (r_wt),
                .pos       (pos_a[g]),
                .wt        (wt_a[g]),
                .gt        (gt_a[g])
            );
        end
    endgenerate

    // Cell 0 presents the next lowest entry during the scan.
    assign acc_next = acc_reg + TOT_W'(wt_a[0]);
    assign hit      = {acc_next, 1'b0} >= {1'b0, total_reg};
    assign last_one = (CNT_W'(idx_reg + CNT_W'(1)) == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            total_reg     <= '0;
            acc_reg       <= '0;
            drop_reg      <= 1'b0;
            half_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_pos_reg   <= '0;
            out_total_reg <= '0;
            out_count_reg <= '0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= load_result || (out_valid_reg && out_stall);

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (!full)
                        begin
                            count_reg <= count_reg + CNT_W'(1);
                            total_reg <= total_reg + TOT_W'(new_wt);
                        end
                        else
                        begin
                            drop_reg <= 1'b1;
                        end
                        if (last_sample)
                        begin
                            acc_reg   <= '0;
                            idx_reg   <= '0;
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    acc_reg <= acc_next;
                    idx_reg <= idx_reg + CNT_W'(1);
                    priority if (hit)
                    begin
                        half_reg  <= pos_a[0];
                        state_reg <= ST_DONE;
                    end
                    else if (last_one)
                    begin
                        half_reg  <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_DONE:
                begin
                    if (load_result)
                    begin
                        out_pos_reg   <= POS_OUT_W'(half_reg);
                        out_total_reg <= (TSAT_W'(total_reg) > TSAT_W'(TOTAL_OUT_MAX))
                                         ? TOTAL_OUT_MAX : TOTAL_OUT_W'(total_reg);
                        out_count_reg <= (CSAT_W'(count_reg) > CSAT_W'(COUNT_OUT_MAX))
                                         ? COUNT_OUT_MAX : COUNT_OUT_W'(count_reg);
                        out_ovf_reg   <= drop_reg;
                        count_reg     <= '0;
                        total_reg     <= '0;
                        drop_reg      <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign halfway_position = out_pos_reg;
    assign total_weight     = out_total_reg;
    assign sample_count     = out_count_reg;
    assign overflowed       = out_ovf_reg;

    // The fill count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SAMPLES))
        else $error("fill count exceeds capacity");

    // A transaction taken while the store is full sets the drop flag.
    a_drop_set: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && full) |=> drop_reg)
        else $error("dropped sample not flagged");

    // The scan never walks past the stored entries.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (idx_reg < count_reg))
        else $error("scan index beyond stored count");

    // Loading a result empties the store for the next set.
    a_empty_after: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_free) |=>
            (count_reg == '0 && total_reg == '0 && !drop_reg && out_valid_reg))
        else $error("store not emptied after result");

    // Inputs are held off for the whole scan.
    a_no_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !ctrl.insert)
        else $error("insertion during scan");

endmodule
